FILE: rtl/tpfc_pkg.sv
// ============================================================================
// tpfc_pkg
// Shared types, constants and pixel decode/encode functions for the texture
// pixel format converter.
// ============================================================================
package tpfc_pkg;

    // Pixel format codes
    typedef enum logic [2:0] {
        FMT_RGB888    = 3'd0,
        FMT_RGBA8888  = 3'd1,
        FMT_RGBA4444  = 3'd2,
        FMT_RGBA5551  = 3'd3,
        FMT_RGB565    = 3'd4,
        FMT_LUM       = 3'd5,
        FMT_LUM_ALPHA = 3'd6,
        FMT_ALPHA     = 3'd7
    } fmt_t;

    // Register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH     = 2'd2;
    localparam logic [1:0] REG_SOURCE_ALIGN  = 2'd3;

    localparam int ROW_WIDTH_W = 13;
    localparam logic [ROW_WIDTH_W-1:0] MAX_ROW_WIDTH = 13'd4096;

    // Configuration as seen by the front end
    typedef struct packed {
        fmt_t                   source_format;
        fmt_t                   target_format;
        logic [ROW_WIDTH_W-1:0] row_width;
        logic [1:0]             source_align_log2;
    } cfg_t;

    // Encoded target pixel
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nd;
    } enc_t;

    // One queued pixel job for the back end
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nd;
        logic [1:0]      npad;
        logic            row_done;
    } job_t;

    // Source bytes per pixel
    function automatic logic [2:0] fmt_size(input fmt_t fmt);
        logic [2:0] sz;
        case (fmt)
            FMT_RGB888:   sz = 3'd3;
            FMT_RGBA8888: sz = 3'd4;
            FMT_LUM:      sz = 3'd1;
            FMT_ALPHA:    sz = 3'd1;
            default:      sz = 3'd2;
        endcase
        return sz;
    endfunction

    // Widen a source pixel to {r, g, b, a}
    function automatic logic [31:0] decode_pixel(input fmt_t fmt, input logic [31:0] px);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [15:0] pv;
        pv = px[15:0];
        r  = 8'd0;
        g  = 8'd0;
        b  = 8'd0;
        a  = 8'hff;
        case (fmt)
            FMT_RGB888:
            begin
                r = px[7:0];
                g = px[15:8];
                b = px[23:16];
            end
            FMT_RGBA8888:
            begin
                r = px[7:0];
                g = px[15:8];
                b = px[23:16];
                a = px[31:24];
            end
            FMT_RGBA4444:
            begin
                r = {pv[15:12], pv[15:12]};
                g = {pv[11:8], pv[11:8]};
                b = {pv[7:4], pv[7:4]};
                a = {pv[3:0], pv[3:0]};
            end
            FMT_RGBA5551:
            begin
                r = {pv[15:11], pv[15:13]};
                g = {pv[10:6], pv[10:8]};
                b = {pv[5:1], pv[5:3]};
                a = pv[0] ? 8'hff : 8'h00;
            end
            FMT_RGB565:
            begin
                r = {pv[15:11], pv[15:13]};
                g = {pv[10:5], pv[10:9]};
                b = {pv[4:0], pv[4:2]};
            end
            FMT_LUM:
            begin
                r = px[7:0];
                g = px[7:0];
                b = px[7:0];
            end
            FMT_LUM_ALPHA:
            begin
                r = px[7:0];
                g = px[7:0];
                b = px[7:0];
                a = px[15:8];
            end
            default:
            begin
                a = px[7:0];
            end
        endcase
        return {r, g, b, a};
    endfunction

    // Pack {r, g, b, a} into target bytes by truncation
    function automatic enc_t encode_pixel(input fmt_t fmt, input logic [31:0] c);
        enc_t        e;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [15:0] pv;
        r  = c[31:24];
        g  = c[23:16];
        b  = c[15:8];
        a  = c[7:0];
        pv = 16'd0;
        e  = '0;
        case (fmt)
            FMT_RGB888:
            begin
                e.bytes = {8'd0, b, g, r};
                e.nd    = 3'd3;
            end
            FMT_RGBA8888:
            begin
                e.bytes = {a, b, g, r};
                e.nd    = 3'd4;
            end
            FMT_RGBA4444:
            begin
                pv      = {r[7:4], g[7:4], b[7:4], a[7:4]};
                e.bytes = {16'd0, pv[15:8], pv[7:0]};
                e.nd    = 3'd2;
            end
            FMT_RGBA5551:
            begin
                pv      = {r[7:3], g[7:3], b[7:3], a[7]};
                e.bytes = {16'd0, pv[15:8], pv[7:0]};
                e.nd    = 3'd2;
            end
            FMT_RGB565:
            begin
                pv      = {r[7:3], g[7:2], b[7:3]};
                e.bytes = {16'd0, pv[15:8], pv[7:0]};
                e.nd    = 3'd2;
            end
            FMT_LUM:
            begin
                e.bytes = {24'd0, r};
                e.nd    = 3'd1;
            end
            FMT_LUM_ALPHA:
            begin
                e.bytes = {16'd0, a, r};
                e.nd    = 3'd2;
            end
            default:
            begin
                e.bytes = {24'd0, a};
                e.nd    = 3'd1;
            end
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/tpfc_if.sv
// ============================================================================
// tpfc_if
// Valid/ready channels for source bytes and destination bytes.
// ============================================================================
interface tpfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       image_start;

    modport source (output valid, output in_byte, output image_start, input ready);
    modport sink   (input valid, input in_byte, input image_start, output ready);
endinterface

interface tpfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_padding;
    logic       row_end;
    logic       run_last;

    modport source (output valid, output out_byte, output is_padding, output row_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input is_padding, input row_end,
                    input run_last, output ready);
endinterface

FILE: rtl/texture_pixel_format_converter_unit.sv
// ============================================================================
// texture_pixel_format_converter_unit
// Source texture bytes in, converted destination bytes out, with source row
// padding dropped and destination rows padded to a multiple of 4 bytes.
// ============================================================================
// Path: the first destination byte of a pixel goes through the job queue and
//   then the output register once the pixel's last source byte is accepted.
// Throughput: one source byte per cycle while the 4-entry job queue has room;
//   the output register emits one byte per cycle while the sink is ready
//   and a job is queued; a pixel yields 1 to 6 target and padding bytes.
// Reset: rst_n clears all counters, the queue and the output valid; registers
//   return to rgba8888 -> rgba8888, row width 1, source alignment 4 bytes.
module texture_pixel_format_converter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    tpfc_in_if.sink                           src,
    tpfc_out_if.source                        dst,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpfc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tpfc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tpfc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tpfc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    logic       q_push, q_pop, q_full, q_empty;
    job_t       q_in, q_head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_SOURCE_FORMAT: cfg_next.source_format     = fmt_t'(pwdata[2:0]);
                REG_TARGET_FORMAT: cfg_next.target_format     = fmt_t'(pwdata[2:0]);
                REG_ROW_WIDTH:     cfg_next.row_width         = pwdata[ROW_WIDTH_W-1:0];
                REG_SOURCE_ALIGN:  cfg_next.source_align_log2 = pwdata[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format     <= FMT_RGBA8888;
            cfg_reg.target_format     <= FMT_RGBA8888;
            cfg_reg.row_width         <= ROW_WIDTH_W'(1);
            cfg_reg.source_align_log2 <= 2'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_SOURCE_FORMAT: prdata = APB_DATA_W'(cfg_reg.source_format);
            REG_TARGET_FORMAT: prdata = APB_DATA_W'(cfg_reg.target_format);
            REG_ROW_WIDTH:     prdata = APB_DATA_W'(cfg_reg.row_width);
            REG_SOURCE_ALIGN:  prdata = APB_DATA_W'(cfg_reg.source_align_log2);
            default:           prdata = '0;
        endcase
    end

    tpfc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .src    (src),
        .q_full (q_full),
        .push   (q_push),
        .job    (q_in)
    );

    tpfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tpfc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .empty (q_empty),
        .pop   (q_pop),
        .dst   (dst)
    );

endmodule

FILE: rtl/tpfc_front.sv
// ============================================================================
// tpfc_front
// Accepts source bytes, drops source row padding, assembles pixels and
// converts each finished pixel into a job for the back end.
// ============================================================================
module tpfc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  tpfc_pkg::cfg_t     cfg,
    tpfc_in_if.sink            src,
    input  logic               q_full,
    output logic               push,
    output tpfc_pkg::job_t     job
);
    import tpfc_pkg::*;

    logic [31:0]            asm_reg, asm_next;
    logic [1:0]             bip_reg, bip_next;
    logic [ROW_WIDTH_W-1:0] col_reg, col_next;
    logic [2:0]             pad_reg, pad_next;

    logic                   accept;
    logic [31:0]            asm_cur, asm_new;
    logic [1:0]             bip_cur;
    logic [ROW_WIDTH_W-1:0] col_cur, col_inc, width;
    logic [2:0]             pad_cur, sbpp, amask, src_prod;
    logic [1:0]             dst_prod;
    logic                   row_done;
    enc_t                   enc;

    assign src.ready = !q_full;
    assign accept    = src.valid && src.ready;

    // Effective row width
    always_comb
    begin
        width = cfg.row_width;
        if (cfg.row_width == '0)
            width = ROW_WIDTH_W'(1);
        else if (cfg.row_width > MAX_ROW_WIDTH)
            width = MAX_ROW_WIDTH;
    end

    assign sbpp = fmt_size(cfg.source_format);

    // State as seen by this byte (image_start clears first)
    assign asm_cur = src.image_start ? 32'd0 : asm_reg;
    assign bip_cur = src.image_start ? 2'd0 : bip_reg;
    assign col_cur = src.image_start ? '0 : col_reg;
    assign pad_cur = src.image_start ? 3'd0 : pad_reg;

    assign asm_new = (bip_cur == 2'd0) ? {24'd0, src.in_byte}
                                       : (asm_cur | (32'(src.in_byte) << {bip_cur, 3'b000}));

    // Pixel conversion
    assign enc = encode_pixel(cfg.target_format, decode_pixel(cfg.source_format, asm_new));

    assign col_inc  = col_cur + ROW_WIDTH_W'(1);
    assign row_done = (col_inc >= width);

    // Only the low bits of the row byte counts matter for padding
    assign dst_prod = 2'(width[1:0] * enc.nd);
    assign src_prod = 3'(width[2:0] * sbpp);
    assign amask    = 3'((4'd1 << cfg.source_align_log2) - 4'd1);

    always_comb
    begin
        asm_next     = asm_reg;
        bip_next     = bip_reg;
        col_next     = col_reg;
        pad_next     = pad_reg;
        push         = 1'b0;
        job.bytes    = enc.bytes;
        job.nd       = enc.nd;
        job.npad     = row_done ? (2'd0 - dst_prod) : 2'd0;
        job.row_done = row_done;
        if (accept)
        begin
            asm_next = asm_cur;
            bip_next = bip_cur;
            col_next = col_cur;
            pad_next = pad_cur;
            if (pad_cur != 3'd0)
            begin
                // dropped source padding byte
                pad_next = pad_cur - 3'd1;
            end
            else if (({1'b0, bip_cur} + 3'd1) < sbpp)
            begin
                asm_next = asm_new;
                bip_next = bip_cur + 2'd1;
            end
            else
            begin
                asm_next = asm_new;
                bip_next = 2'd0;
                push     = 1'b1;
                if (row_done)
                begin
                    col_next = '0;
                    pad_next = (3'd0 - src_prod) & amask;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_reg <= '0;
            bip_reg <= '0;
            col_reg <= '0;
            pad_reg <= '0;
        end
        else
        begin
            asm_reg <= asm_next;
            bip_reg <= bip_next;
            col_reg <= col_next;
            pad_reg <= pad_next;
        end
    end

endmodule

FILE: rtl/tpfc_queue.sv
// ============================================================================
// tpfc_queue
// Four-entry job queue between the front and back ends.
// ============================================================================
module tpfc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tpfc_pkg::job_t push_job,
    input  logic           pop,
    output tpfc_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import tpfc_pkg::*;

    job_t       mem [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 3'd4);
    assign empty   = (cnt_reg == 3'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rptr_reg];

    // Pointer and count update
    always_comb
    begin
        wptr_next = do_push ? wptr_reg + 2'd1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 2'd1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 3'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= push_job;
    end

endmodule

FILE: rtl/tpfc_back.sv
// ============================================================================
// tpfc_back
// Walks each queued job and emits its target and padding bytes, one item per
// cycle while the sink is ready and a job is queued, through an output register.
// ============================================================================
module tpfc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tpfc_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    tpfc_out_if.source     dst
);
    import tpfc_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    logic [7:0] byte_reg, byte_next;
    logic       pad_reg, pad_next;
    logic       end_reg, end_next;
    logic       last_reg, last_next;

    logic       load, last, is_pad;
    logic [2:0] total;

    assign load   = !empty && (!vld_reg || dst.ready);
    assign total  = head.nd + {1'b0, head.npad};
    assign last   = (idx_reg + 3'd1) == total;
    assign is_pad = idx_reg >= head.nd;
    assign pop    = load && last;

    always_comb
    begin
        idx_next  = idx_reg;
        vld_next  = dst.ready ? 1'b0 : vld_reg;
        byte_next = byte_reg;
        pad_next  = pad_reg;
        end_next  = end_reg;
        last_next = last_reg;
        if (load)
        begin
            idx_next  = last ? 3'd0 : idx_reg + 3'd1;
            vld_next  = 1'b1;
            byte_next = is_pad ? 8'd0 : head.bytes[idx_reg[1:0]];
            pad_next  = is_pad;
            end_next  = head.row_done && last;
            last_next = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        pad_reg  <= pad_next;
        end_reg  <= end_next;
        last_reg <= last_next;
    end

    assign dst.valid      = vld_reg;
    assign dst.out_byte   = byte_reg;
    assign dst.is_padding = pad_reg;
    assign dst.row_end    = end_reg;
    assign dst.run_last   = last_reg;

endmodule
